// File: rtl/dpt_pkg.sv
// shared types, codes and sizing constants for the demand paging translator
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package dpt_pkg;

	localparam int MAX_LOGICAL_WORDS = 32;
	localparam int MAX_RAM_WORDS     = 8;
	localparam int MAX_PAGE_WORDS    = 2;

	localparam int VPN_W   = $clog2(MAX_LOGICAL_WORDS);
	localparam int FRAME_W = $clog2(MAX_RAM_WORDS);

	// access kinds
	localparam logic [1:0] FUNC_READ   = 2'd0;
	localparam logic [1:0] FUNC_WRITE  = 2'd1;
	localparam logic [1:0] FUNC_SEARCH = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_HIT      = 2'd0;
	localparam logic [1:0] STAT_LOADED   = 2'd1;
	localparam logic [1:0] STAT_NO_FRAME = 2'd2;
	localparam logic [1:0] STAT_INVALID  = 2'd3;

	// register indexes
	localparam logic [1:0] CFG_PAGE_WORDS    = 2'd0;
	localparam logic [1:0] CFG_RAM_WORDS     = 2'd1;
	localparam logic [1:0] CFG_PROCESS_WORDS = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic               valid;
		logic               referenced;
		logic               modified;
		logic [FRAME_W-1:0] frame;
	} pte_t;

	typedef struct packed {
		logic             start;
		logic [FRAME_W:0] nframes;
	} scan_ctrl_t;

	typedef struct packed {
		logic               done;
		logic               found;
		logic [FRAME_W-1:0] frame;
	} scan_stat_t;

endpackage

`default_nettype wire

// File: rtl/demand_paging_translator.sv
// flow: an access is taken in idle and looked up in the lookup state; a hit or an invalid
// access goes straight to finish, while a miss first scans the frames for a free one
// throughput: one access at a time, the next is taken the cycle after the result moves
// to the output register; the frame scan loop sets the miss cost and a stalled result
// holds the block in its finish state
// reset: all page entries invalid, every frame free, registers at 1, 8 and 32 words
`default_nettype none

module demand_paging_translator (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [5:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] func,
	input  wire logic [4:0] address,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      status,
	output logic [2:0]      physical_address,
	output logic [2:0]      frame_number,
	output logic            modified_flag
);

	localparam int VW = dpt_pkg::VPN_W;
	localparam int FW = dpt_pkg::FRAME_W;

	dpt_pkg::state_t state_q, state_d;

	logic [1:0] page_words_q;
	logic [3:0] ram_words_q;
	logic [5:0] process_words_q;

	logic [1:0] func_q;
	logic [4:0] address_q;

	logic [1:0]    res_status_q, res_status_d;
	logic [2:0]    res_phys_q, res_phys_d;
	logic [FW-1:0] res_frame_q, res_frame_d;
	logic          res_mod_q, res_mod_d;
	logic          res_load;

	logic [1:0]    out_status_q;
	logic [2:0]    out_phys_q;
	logic [FW-1:0] out_frame_q;
	logic          out_mod_q;

	logic          out_valid_q;
	logic          out_free;

	logic          page_sh;
	logic [3:0]    eff_ram;
	logic [5:0]    eff_process;
	logic [VW-1:0] vpage;
	logic          offset;
	logic          addr_ok;
	logic          is_write;

	dpt_pkg::pte_t       rd_entry;
	dpt_pkg::pte_t       wr_entry;
	logic                wr_en;
	dpt_pkg::scan_ctrl_t scan_ctrl;
	dpt_pkg::scan_stat_t scan_stat;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != dpt_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign status           = out_status_q;
	assign physical_address = out_phys_q;
	assign frame_number     = out_frame_q;
	assign modified_flag    = out_mod_q;

	// page size is 1 or 2 words, so divide and multiply are a one-bit shift
	assign page_sh     = page_words_q[1];
	assign eff_ram     = (ram_words_q > 4'(dpt_pkg::MAX_RAM_WORDS)) ?
	                     4'(dpt_pkg::MAX_RAM_WORDS) : ram_words_q;
	assign eff_process = (process_words_q > 6'(dpt_pkg::MAX_LOGICAL_WORDS)) ?
	                     6'(dpt_pkg::MAX_LOGICAL_WORDS) : process_words_q;
	assign vpage       = page_sh ? VW'(address_q >> 1) : VW'(address_q);
	assign offset      = page_sh & address_q[0];
	assign is_write    = (func_q == dpt_pkg::FUNC_WRITE);
	assign addr_ok     = (func_q inside {dpt_pkg::FUNC_READ, dpt_pkg::FUNC_WRITE,
	                                     dpt_pkg::FUNC_SEARCH}) &&
	                     ({1'b0, address_q} < eff_process);

	function automatic logic [2:0] phys_of(input logic [FW-1:0] f, input logic sh,
	                                       input logic off);
		logic [FW:0] base;
		base = sh ? {f, 1'b0} : {1'b0, f};
		return 3'(base | (FW+1)'(off));
	endfunction

	dpt_pte_store u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (vpage),
		.rd_entry (rd_entry),
		.wr_en    (wr_en),
		.wr_idx   (vpage),
		.wr_entry (wr_entry)
	);

	dpt_frame_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (scan_ctrl),
		.stat   (scan_stat)
	);

	always_comb begin
		state_d           = state_q;
		wr_en             = 1'b0;
		wr_entry          = rd_entry;
		scan_ctrl.start   = 1'b0;
		scan_ctrl.nframes = page_sh ? (eff_ram >> 1) : eff_ram;
		res_load          = 1'b0;
		res_status_d      = dpt_pkg::STAT_INVALID;
		res_phys_d        = '0;
		res_frame_d       = '0;
		res_mod_d         = 1'b0;
		case (state_q)
			dpt_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = dpt_pkg::S_LOOKUP;
				end
			end
			dpt_pkg::S_LOOKUP: begin
				if (!addr_ok) begin
					res_load = 1'b1;
					state_d  = dpt_pkg::S_FINISH;
				end else if (rd_entry.valid) begin
					wr_en               = 1'b1;
					wr_entry.referenced = 1'b1;
					wr_entry.modified   = rd_entry.modified | is_write;
					res_load            = 1'b1;
					res_status_d        = dpt_pkg::STAT_HIT;
					res_frame_d         = rd_entry.frame;
					res_phys_d          = phys_of(rd_entry.frame, page_sh, offset);
					res_mod_d           = rd_entry.modified | is_write;
					state_d             = dpt_pkg::S_FINISH;
				end else begin
					scan_ctrl.start = 1'b1;
					state_d         = dpt_pkg::S_SCAN;
				end
			end
			dpt_pkg::S_SCAN: begin
				if (scan_stat.done) begin
					res_load = 1'b1;
					state_d  = dpt_pkg::S_FINISH;
					if (scan_stat.found) begin
						wr_en               = 1'b1;
						wr_entry.valid      = 1'b1;
						wr_entry.referenced = 1'b1;
						wr_entry.modified   = rd_entry.modified | is_write;
						wr_entry.frame      = scan_stat.frame;
						res_status_d        = dpt_pkg::STAT_LOADED;
						res_frame_d         = scan_stat.frame;
						res_phys_d          = phys_of(scan_stat.frame, page_sh, offset);
						res_mod_d           = rd_entry.modified | is_write;
					end else begin
						res_status_d = dpt_pkg::STAT_NO_FRAME;
						res_mod_d    = rd_entry.modified;
					end
				end
			end
			dpt_pkg::S_FINISH: begin
				if (out_free) begin
					state_d = dpt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dpt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_words_q    <= 2'd1;
			ram_words_q     <= 4'd8;
			process_words_q <= 6'd32;
		end else if (cfg_valid) begin
			case (cfg_index)
				dpt_pkg::CFG_PAGE_WORDS:    page_words_q    <= cfg_data[1:0];
				dpt_pkg::CFG_RAM_WORDS:     ram_words_q     <= cfg_data[3:0];
				dpt_pkg::CFG_PROCESS_WORDS: process_words_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// accepted word and pending result
	always_ff @(posedge clk) begin
		if (state_q == dpt_pkg::S_IDLE && in_valid) begin
			func_q    <= func;
			address_q <= address;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_phys_q   <= res_phys_d;
			res_frame_q  <= res_frame_d;
			res_mod_q    <= res_mod_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == dpt_pkg::S_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register fields: loaded from the pending result on finish
	// the pending result registers hold until the next lookup or scan loads them
	always_ff @(posedge clk) begin
		if (state_q == dpt_pkg::S_FINISH && out_free) begin
			out_status_q <= res_status_q;
			out_phys_q   <= res_phys_q;
			out_frame_q  <= res_frame_q;
			out_mod_q    <= res_mod_q;
		end
	end

endmodule

`default_nettype wire

// File: rtl/dpt_page_table.sv
// page table entry storage: one read port, one write port
// depends on dpt_pkg for the entry type and table depth
`default_nettype none

module dpt_pte_store (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [dpt_pkg::VPN_W-1:0] rd_idx,
	output dpt_pkg::pte_t               rd_entry,
	input  wire logic                   wr_en,
	input  wire logic [dpt_pkg::VPN_W-1:0] wr_idx,
	input  wire dpt_pkg::pte_t          wr_entry
);

	dpt_pkg::pte_t entries_q [dpt_pkg::MAX_LOGICAL_WORDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '{default: '0};
		end else if (wr_en) begin
			entries_q[wr_idx] <= wr_entry;
		end
	end

	assign rd_entry = entries_q[rd_idx];

endmodule

`default_nettype wire

// File: rtl/dpt_frame_scan.sv
// free frame scan: one frame checked per cycle with a single compare,
// owns the frame in-use bits; depends on dpt_pkg
`default_nettype none

module dpt_frame_scan (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire dpt_pkg::scan_ctrl_t ctrl,
	output dpt_pkg::scan_stat_t stat
);

	localparam int FW = dpt_pkg::FRAME_W;

	logic [dpt_pkg::MAX_RAM_WORDS-1:0] in_use_q;
	logic [FW:0]                       cnt_q;
	logic                              active_q;
	logic [FW-1:0]                     idx;
	logic                              in_range;
	logic                              hit_free;

	assign idx      = cnt_q[FW-1:0];
	assign in_range = cnt_q < ctrl.nframes;
	assign hit_free = in_range && !in_use_q[idx];

	always_comb begin
		stat.done  = active_q && (!in_range || hit_free);
		stat.found = active_q && hit_free;
		stat.frame = idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			cnt_q    <= '0;
			active_q <= 1'b0;
		end else if (ctrl.start) begin
			cnt_q    <= '0;
			active_q <= 1'b1;
		end else if (active_q) begin
			if (!in_range) begin
				active_q <= 1'b0;
			end else if (hit_free) begin
				in_use_q[idx] <= 1'b1;
				active_q      <= 1'b0;
			end else begin
				cnt_q <= cnt_q + (FW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire
